>>> rtl/lts_pkg.sv
// Package for the Lua token scanner: widths, token codes, scan modes, keyword table.
`timescale 1ns / 1ps
package lts_pkg;

    localparam int OFS_BITS   = 24;
    localparam int LVL_BITS   = 8;
    localparam int KW_MAX_LEN = 8;
    localparam int KW_COUNT   = 21;
    localparam int FIFO_DEPTH = 4;

    localparam logic [OFS_BITS-1:0] OFS_MAX   = {OFS_BITS{1'b1}};
    localparam logic [LVL_BITS-1:0] LVL_MAX   = 8'd255;

    // token codes
    localparam logic [5:0] TK_EOF      = 6'd0;
    localparam logic [5:0] TK_ERR      = 6'd1;
    localparam logic [5:0] TK_NAME     = 6'd2;
    localparam logic [5:0] TK_NUM      = 6'd3;
    localparam logic [5:0] TK_STR      = 6'd4;
    localparam logic [5:0] TK_KW_BASE  = 6'd5;
    localparam logic [5:0] TK_ADD      = 6'd26;
    localparam logic [5:0] TK_SUB      = 6'd27;
    localparam logic [5:0] TK_MUL      = 6'd28;
    localparam logic [5:0] TK_DIV      = 6'd29;
    localparam logic [5:0] TK_MOD      = 6'd30;
    localparam logic [5:0] TK_POW      = 6'd31;
    localparam logic [5:0] TK_LEN      = 6'd32;
    localparam logic [5:0] TK_EQ       = 6'd33;
    localparam logic [5:0] TK_NE       = 6'd34;
    localparam logic [5:0] TK_LE       = 6'd35;
    localparam logic [5:0] TK_GE       = 6'd36;
    localparam logic [5:0] TK_LT       = 6'd37;
    localparam logic [5:0] TK_GT       = 6'd38;
    localparam logic [5:0] TK_ASSIGN   = 6'd39;
    localparam logic [5:0] TK_LPAREN   = 6'd40;
    localparam logic [5:0] TK_RPAREN   = 6'd41;
    localparam logic [5:0] TK_LBRACE   = 6'd42;
    localparam logic [5:0] TK_RBRACE   = 6'd43;
    localparam logic [5:0] TK_LBRACKET = 6'd44;
    localparam logic [5:0] TK_RBRACKET = 6'd45;
    localparam logic [5:0] TK_SEMI     = 6'd46;
    localparam logic [5:0] TK_COLON    = 6'd47;
    localparam logic [5:0] TK_COMMA    = 6'd48;
    localparam logic [5:0] TK_DOT      = 6'd49;
    localparam logic [5:0] TK_CONCAT   = 6'd50;
    localparam logic [5:0] TK_DOTS     = 6'd51;
    localparam logic [5:0] TK_DBCOLON  = 6'd52;
    localparam logic [5:0] TK_TILDE    = 6'd53;

    typedef enum logic [4:0] {
        MD_SOF, MD_HASH, MD_SINK, MD_SHEBANG, MD_IDLE, MD_MINUS, MD_CSTART, MD_SCOM,
        MD_CSEP, MD_SQSEP, MD_OP2, MD_DOT, MD_DOT2, MD_STR, MD_ESC, MD_DEC, MD_HEX,
        MD_ZAP, MD_NUM_ZERO, MD_NUM_HEX, MD_NUM_MAIN, MD_NUM_AFTER, MD_NUM_EXP,
        MD_NAME, MD_LSTR_FIRST, MD_LSTR, MD_LSTR_CLOSE, MD_LCOM_FIRST, MD_LCOM,
        MD_LCOM_CLOSE, MD_DONE
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [LVL_BITS-1:0] open_lv;
        logic [LVL_BITS-1:0] close_lv;
        logic [7:0]          quote;
        logic [9:0]          esc_val;
        logic [1:0]          esc_dig;
        logic [3:0]          wlen;
        logic [OFS_BITS-1:0] start;
        logic [OFS_BITS-1:0] line;
    } t_scan;

    typedef struct packed {
        logic [5:0]          typ;
        logic [OFS_BITS-1:0] ts;
        logic [OFS_BITS-1:0] te;
        logic [OFS_BITS-1:0] ln;
        logic                last;
    } t_res;

    // keywords, left aligned, first character in the top byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"and", 40'd0}, {"break", 24'd0}, {"do", 48'd0}, {"else", 32'd0},
        {"elseif", 16'd0}, {"end", 40'd0}, {"false", 24'd0}, {"for", 40'd0},
        "function", {"if", 48'd0}, {"in", 48'd0}, {"local", 24'd0},
        {"nil", 40'd0}, {"not", 40'd0}, {"or", 48'd0}, {"repeat", 16'd0},
        {"return", 16'd0}, {"then", 32'd0}, {"true", 32'd0}, {"until", 24'd0},
        {"while", 24'd0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd8, 4'd2, 4'd2,
        4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5
    };

endpackage

>>> rtl/lts_if.sv
// Stream interfaces for the Lua token scanner: byte input and token output.
`timescale 1ns / 1ps
interface lts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_marker;
    modport source (output valid, char_code, end_marker, input ready);
    modport sink   (input valid, char_code, end_marker, output ready);
endinterface

interface lts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_type;
    logic [23:0] token_start;
    logic [23:0] token_end;
    logic [23:0] line_number;
    logic        last_result;
    modport source (output valid, token_type, token_start, token_end, line_number,
                    last_result, input ready);
    modport sink   (input valid, token_type, token_start, token_end, line_number,
                    last_result, output ready);
endinterface

>>> rtl/lua_token_scanner.sv
// Top level of the Lua token scanner: byte-wise lexer with a token output queue.
`timescale 1ns / 1ps
// Lua 5.2 token scanner. One source byte (or the end marker) is taken per
// transfer on i_src; each transfer yields zero, one or two tokens on o_tok,
// the last of them flagged by last_result. A byte is taken in every cycle
// while the four-entry token queue has two free slots, so the sustained rate
// is one byte per cycle and drops only while the token sink stalls or tokens
// come out faster than one per cycle. The whole mode update of a byte,
// including the re-scan of a byte that ends a pending token (up to four
// chained mode steps), and the parallel compare of the eight-byte name
// buffer against the 21 keywords are settled in the accepting cycle; tokens
// are written into the token queue at the byte transfer. Offsets and line
// count saturate at 2^24-1; '\n' and '\r' each count a line. After the end
// marker bytes are ignored and a further end marker reports end-of-file again.
module lua_token_scanner
    import lts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    lts_in_if.sink        i_src,
    lts_out_if.source     o_tok
);

    // longest chain: zero digit, number tail, number end, idle
    localparam int NPASS = 4;

    localparam t_scan SCAN_RST = '{
        mode:     MD_SOF,
        open_lv:  '0,
        close_lv: '0,
        quote:    '0,
        esc_val:  '0,
        esc_dig:  '0,
        wlen:     '0,
        start:    '0,
        line:     OFS_BITS'(1)
    };

    // ---------------------------------------------------------------
    // character classes
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction
    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction
    function automatic logic is_nl(input logic [7:0] c);
        return (c == 8'h0a) || (c == 8'h0d);
    endfunction
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0b) || (c == 8'h0c);
    endfunction
    function automatic logic [OFS_BITS-1:0] sat_inc(input logic [OFS_BITS-1:0] v);
        return (v == OFS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [5:0] single_type(input logic [7:0] c);
        logic [5:0] t;
        case (c)
            "+":     t = TK_ADD;
            "*":     t = TK_MUL;
            "/":     t = TK_DIV;
            "%":     t = TK_MOD;
            "^":     t = TK_POW;
            "#":     t = TK_LEN;
            "(":     t = TK_LPAREN;
            ")":     t = TK_RPAREN;
            "{":     t = TK_LBRACE;
            "}":     t = TK_RBRACE;
            "]":     t = TK_RBRACKET;
            ";":     t = TK_SEMI;
            ",":     t = TK_COMMA;
            default: t = TK_ERR;
        endcase
        return t;
    endfunction

    function automatic logic [5:0] op2_type(input logic [7:0] q, input logic pair);
        logic [5:0] t;
        case (q)
            "=":     t = pair ? TK_EQ : TK_ASSIGN;
            "<":     t = pair ? TK_LE : TK_LT;
            ">":     t = pair ? TK_GE : TK_GT;
            "~":     t = pair ? TK_NE : TK_TILDE;
            default: t = pair ? TK_DBCOLON : TK_COLON;
        endcase
        return t;
    endfunction

    typedef struct packed {
        t_scan               s;
        logic                redo;
        logic                emit;
        logic [5:0]          typ;
        logic [OFS_BITS-1:0] ts;
        logic [OFS_BITS-1:0] te;
        logic [OFS_BITS-1:0] ln;
        logic                we;
        logic [2:0]          widx;
    } t_pass;

    // one step of the scan state machine on byte c at offset p
    function automatic t_pass do_pass(input t_scan s, input logic [7:0] c,
                                      input logic [OFS_BITS-1:0] p,
                                      input logic [OFS_BITS-1:0] nx,
                                      input logic [5:0] wtype);
        t_pass o;
        logic  pair;
        logic [9:0] dv;
        logic [1:0] dd;
        o      = '0;
        o.s    = s;
        o.ts   = s.start;
        o.te   = p;
        o.ln   = s.line;
        pair   = (s.quote == ":") ? (c == ":") : (c == "=");
        dv     = (s.esc_val << 3) + (s.esc_val << 1) + {2'b00, c - 8'h30};
        dd     = s.esc_dig + 2'd1;
        case (s.mode)
            MD_SOF: begin
                if (c == "#") o.s.mode = MD_HASH;
                else begin o.s.mode = MD_IDLE; o.redo = 1'b1; end
            end
            MD_HASH: o.s.mode = (c == "!") ? MD_SHEBANG : MD_SINK;
            MD_SHEBANG, MD_SCOM: begin
                if (is_nl(c)) begin o.s.line = sat_inc(s.line); o.s.mode = MD_IDLE; end
            end
            MD_IDLE: begin
                o.s.start = p;
                if (is_nl(c)) o.s.line = sat_inc(s.line);
                else if (is_space(c)) o.s.mode = MD_IDLE;
                else if (c == "-") o.s.mode = MD_MINUS;
                else if (c == "[") begin o.s.open_lv = '0; o.s.mode = MD_SQSEP; end
                else if (c inside {"=", "<", ">", "~", ":"}) begin
                    o.s.quote = c; o.s.mode = MD_OP2;
                end else if (c inside {8'h22, 8'h27}) begin
                    o.s.quote = c; o.s.mode = MD_STR;
                end else if (c == ".") o.s.mode = MD_DOT;
                else if (is_digit(c)) o.s.mode = (c == "0") ? MD_NUM_ZERO : MD_NUM_AFTER;
                else if (is_alpha(c)) begin
                    o.we = 1'b1; o.widx = 3'd0; o.s.wlen = 4'd1; o.s.mode = MD_NAME;
                end else begin
                    o.emit = 1'b1; o.typ = single_type(c); o.ts = p; o.te = nx;
                end
            end
            MD_MINUS: begin
                if (c == "-") o.s.mode = MD_CSTART;
                else begin o.emit = 1'b1; o.typ = TK_SUB; o.s.mode = MD_IDLE; o.redo = 1'b1; end
            end
            MD_CSTART: begin
                if (c == "[") begin o.s.open_lv = '0; o.s.mode = MD_CSEP; end
                else begin o.s.mode = MD_SCOM; o.redo = 1'b1; end
            end
            MD_CSEP, MD_SQSEP: begin
                if (c == "=") begin
                    if (s.open_lv < LVL_MAX) o.s.open_lv = s.open_lv + 1'b1;
                end else if (c == "[") begin
                    o.s.mode = (s.mode == MD_CSEP) ? MD_LCOM_FIRST : MD_LSTR_FIRST;
                end else if (s.mode == MD_CSEP) begin
                    o.s.mode = MD_SCOM; o.redo = 1'b1;
                end else begin
                    o.emit = 1'b1; o.typ = (s.open_lv == '0) ? TK_LBRACKET : TK_ERR;
                    o.s.mode = MD_IDLE; o.redo = 1'b1;
                end
            end
            MD_LSTR_FIRST, MD_LCOM_FIRST: begin
                o.s.mode = (s.mode == MD_LSTR_FIRST) ? MD_LSTR : MD_LCOM;
                if (is_nl(c)) o.s.line = sat_inc(s.line);
                else o.redo = 1'b1;
            end
            MD_LSTR, MD_LCOM: begin
                if (c == "]") begin
                    o.s.close_lv = '0;
                    o.s.mode = (s.mode == MD_LSTR) ? MD_LSTR_CLOSE : MD_LCOM_CLOSE;
                end else if (is_nl(c)) o.s.line = sat_inc(s.line);
            end
            MD_LSTR_CLOSE, MD_LCOM_CLOSE: begin
                if (c == "=") begin
                    if (s.close_lv < LVL_MAX) o.s.close_lv = s.close_lv + 1'b1;
                end else if (c == "]") begin
                    if (s.close_lv == s.open_lv) begin
                        if (s.mode == MD_LSTR_CLOSE) begin
                            o.emit = 1'b1; o.typ = TK_STR; o.te = nx;
                        end
                        o.s.mode = MD_IDLE;
                    end else o.s.close_lv = '0;
                end else begin
                    o.s.mode = (s.mode == MD_LSTR_CLOSE) ? MD_LSTR : MD_LCOM;
                    o.redo = 1'b1;
                end
            end
            MD_OP2: begin
                o.emit = 1'b1; o.typ = op2_type(s.quote, pair); o.s.mode = MD_IDLE;
                if (pair) o.te = nx;
                else o.redo = 1'b1;
            end
            MD_DOT: begin
                if (c == ".") o.s.mode = MD_DOT2;
                else if (is_digit(c)) o.s.mode = (c == "0") ? MD_NUM_ZERO : MD_NUM_AFTER;
                else begin o.emit = 1'b1; o.typ = TK_DOT; o.s.mode = MD_IDLE; o.redo = 1'b1; end
            end
            MD_DOT2: begin
                o.emit = 1'b1; o.s.mode = MD_IDLE;
                if (c == ".") begin o.typ = TK_DOTS; o.te = nx; end
                else begin o.typ = TK_CONCAT; o.redo = 1'b1; end
            end
            MD_STR: begin
                if (c == s.quote) begin
                    o.emit = 1'b1; o.typ = TK_STR; o.te = nx; o.s.mode = MD_IDLE;
                end else if (is_nl(c)) begin
                    o.emit = 1'b1; o.typ = TK_ERR; o.s.mode = MD_IDLE; o.redo = 1'b1;
                end else if (c == 8'h5c) o.s.mode = MD_ESC;
            end
            MD_ESC: begin
                if (c == "x") begin o.s.esc_dig = '0; o.s.mode = MD_HEX; end
                else if (is_nl(c)) begin o.s.line = sat_inc(s.line); o.s.mode = MD_STR; end
                else if (c == "z") o.s.mode = MD_ZAP;
                else if (c == 8'h00) begin
                    o.emit = 1'b1; o.typ = TK_ERR; o.s.mode = MD_IDLE; o.redo = 1'b1;
                end else if (is_digit(c)) begin
                    o.s.esc_val = {2'b00, c - 8'h30}; o.s.esc_dig = 2'd1; o.s.mode = MD_DEC;
                end else begin
                    o.s.mode = MD_STR;
                    o.redo = !(c inside {8'h5c, 8'h22, 8'h27});
                end
            end
            MD_DEC: begin
                if (is_digit(c)) begin
                    o.s.esc_val = dv;
                    o.s.esc_dig = dd;
                    if (dd == 2'd3) begin
                        if (dv > 10'd255) begin
                            o.emit = 1'b1; o.typ = TK_ERR; o.te = nx; o.s.mode = MD_IDLE;
                        end else o.s.mode = MD_STR;
                    end
                end else begin o.s.mode = MD_STR; o.redo = 1'b1; end
            end
            MD_HEX: begin
                if (is_hex(c)) begin
                    if (s.esc_dig != '0) o.s.mode = MD_STR;
                    else o.s.esc_dig = 2'd1;
                end else begin
                    o.emit = 1'b1; o.typ = TK_ERR; o.s.mode = MD_IDLE; o.redo = 1'b1;
                end
            end
            MD_ZAP: begin
                if (is_nl(c)) o.s.line = sat_inc(s.line);
                else if (!is_space(c)) begin o.s.mode = MD_STR; o.redo = 1'b1; end
            end
            MD_NUM_ZERO: begin
                if (c == "x" || c == "X") o.s.mode = MD_NUM_HEX;
                else begin o.s.mode = MD_NUM_AFTER; o.redo = 1'b1; end
            end
            MD_NUM_HEX: begin
                if (!(is_alpha(c) && c != "_") && !is_digit(c)) begin
                    o.s.mode = MD_NUM_MAIN; o.redo = 1'b1;
                end
            end
            MD_NUM_AFTER: begin
                if (c == "e" || c == "E") o.s.mode = MD_NUM_EXP;
                else begin o.s.mode = MD_NUM_MAIN; o.redo = 1'b1; end
            end
            MD_NUM_EXP: begin
                o.s.mode = MD_NUM_MAIN;
                o.redo = !(c == "+" || c == "-");
            end
            MD_NUM_MAIN: begin
                if (is_digit(c) || c == ".") o.s.mode = MD_NUM_AFTER;
                else begin o.emit = 1'b1; o.typ = TK_NUM; o.s.mode = MD_IDLE; o.redo = 1'b1; end
            end
            MD_NAME: begin
                if (is_alpha(c) || is_digit(c)) begin
                    if (s.wlen < 4'(KW_MAX_LEN)) begin o.we = 1'b1; o.widx = s.wlen[2:0]; end
                    if (s.wlen <= 4'(KW_MAX_LEN)) o.s.wlen = s.wlen + 1'b1;
                end else begin
                    o.emit = 1'b1; o.typ = wtype; o.s.mode = MD_IDLE; o.redo = 1'b1;
                end
            end
            default: o.s.mode = s.mode;     // sink and done drop bytes
        endcase
        return o;
    endfunction

    // ---------------------------------------------------------------
    t_scan               r_scan, n_scan;
    logic [OFS_BITS-1:0] r_ofs, n_ofs;
    logic [7:0]          r_word [KW_MAX_LEN];
    t_res                r_fifo [FIFO_DEPTH];
    logic [1:0]          r_head, r_tail;
    logic [2:0]          r_count;

    logic        take, pop, wr_en;
    logic [2:0]  wr_idx;
    logic [1:0]  n_emit;
    t_res        res0, res1;
    logic [5:0]  wtype;
    logic [63:0] wpacked;
    logic [63:0] wmask;

    // keyword match over the name buffer
    always_comb begin
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            wpacked[63-8*i -: 8] = r_word[i];
            wmask[63-8*i -: 8]   = (4'(i) < r_scan.wlen) ? 8'hff : 8'h00;
        end
        wtype = TK_NAME;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (KW_LEN[k] == r_scan.wlen && ((KW_TEXT[k] ^ wpacked) & wmask) == '0)
                wtype = TK_KW_BASE + 6'(k);
        end
    end

    assign i_src.ready = (r_count <= 3'(FIFO_DEPTH - 2));
    assign take        = i_src.valid && i_src.ready;
    assign pop         = o_tok.valid && o_tok.ready;

    // byte scan: chained mode steps, or end-of-input flush
    always_comb begin
        t_scan cur;
        t_pass ps;
        logic  act;
        logic [OFS_BITS-1:0] nx;
        logic [5:0] pt;
        logic  pend;
        cur    = r_scan;
        act    = 1'b1;
        n_emit = '0;
        wr_en  = 1'b0;
        wr_idx = '0;
        res0   = '0;
        res1   = '0;
        ps     = '0;
        pt     = TK_EOF;
        pend   = 1'b0;
        nx     = sat_inc(r_ofs);
        n_ofs  = r_ofs;
        if (i_src.end_marker) begin
            case (r_scan.mode)
                MD_HASH, MD_SINK: begin pend = 1'b1; pt = TK_ERR; end
                MD_MINUS:         begin pend = 1'b1; pt = TK_SUB; end
                MD_SQSEP: begin
                    pend = 1'b1; pt = (r_scan.open_lv == '0) ? TK_LBRACKET : TK_ERR;
                end
                MD_OP2:  begin pend = 1'b1; pt = op2_type(r_scan.quote, 1'b0); end
                MD_DOT:  begin pend = 1'b1; pt = TK_DOT; end
                MD_DOT2: begin pend = 1'b1; pt = TK_CONCAT; end
                MD_STR, MD_ESC, MD_DEC, MD_HEX, MD_ZAP,
                MD_LSTR_FIRST, MD_LSTR, MD_LSTR_CLOSE: begin pend = 1'b1; pt = TK_ERR; end
                MD_NUM_ZERO, MD_NUM_HEX, MD_NUM_MAIN, MD_NUM_AFTER, MD_NUM_EXP: begin
                    pend = 1'b1; pt = TK_NUM;
                end
                MD_NAME: begin pend = 1'b1; pt = wtype; end
                default: pend = 1'b0;
            endcase
            res0.typ = pend ? pt : TK_EOF;
            res0.ts  = (r_scan.mode == MD_HASH || r_scan.mode == MD_SINK || !pend)
                       ? r_ofs : r_scan.start;
            res0.te  = r_ofs;
            res0.ln  = r_scan.line;
            res0.last = !pend;
            res1.typ = TK_EOF;
            res1.ts  = r_ofs;
            res1.te  = r_ofs;
            res1.ln  = r_scan.line;
            res1.last = 1'b1;
            n_emit   = pend ? 2'd2 : 2'd1;
            cur.mode = MD_DONE;
        end else begin
            n_ofs = nx;
            for (int k = 0; k < NPASS; k++) begin
                if (act) begin
                    ps = do_pass(cur, i_src.char_code, r_ofs, nx, wtype);
                    cur = ps.s;
                    act = ps.redo;
                    if (ps.we) begin wr_en = 1'b1; wr_idx = ps.widx; end
                    if (ps.emit) begin
                        if (n_emit == 2'd0) begin
                            res0.typ = ps.typ; res0.ts = ps.ts; res0.te = ps.te;
                            res0.ln = ps.ln;
                        end else begin
                            res1.typ = ps.typ; res1.ts = ps.ts; res1.te = ps.te;
                            res1.ln = ps.ln;
                        end
                        n_emit = n_emit + 2'd1;
                    end
                end
            end
            res0.last = (n_emit == 2'd1);
            res1.last = 1'b1;
        end
        n_scan = cur;
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RST;
            r_ofs  <= '0;
        end else if (take) begin
            r_scan <= n_scan;
            r_ofs  <= n_ofs;
        end
    end

    // name buffer, written only while a name is collected
    always_ff @(posedge i_clk) begin
        if (take && !i_src.end_marker && wr_en) r_word[wr_idx] <= i_src.char_code;
    end

    // token queue
    always_ff @(posedge i_clk) begin
        if (take && n_emit != 2'd0) r_fifo[r_tail] <= res0;
        if (take && n_emit == 2'd2) r_fifo[r_tail + 2'd1] <= res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (pop) r_head <= r_head + 2'd1;
            if (take) r_tail <= r_tail + n_emit;
            r_count <= r_count + (take ? {1'b0, n_emit} : 3'd0) - {2'b00, pop};
        end
    end

    assign o_tok.valid       = (r_count != '0);
    assign o_tok.token_type  = r_fifo[r_head].typ;
    assign o_tok.token_start = r_fifo[r_head].ts;
    assign o_tok.token_end   = r_fifo[r_head].te;
    assign o_tok.line_number = r_fifo[r_head].ln;
    assign o_tok.last_result = r_fifo[r_head].last;

endmodule
